>>> rtl/core/compare_capture_timer_macros.svh
// Assertion helpers used by the timer RTL.
`ifndef COMPARE_CAPTURE_TIMER_MACROS_SVH
`define COMPARE_CAPTURE_TIMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cct assertion failed");

// Next-cycle implication, disabled during reset.
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cct assertion failed");

`endif

>>> rtl/core/cct_pkg.sv
`default_nettype none
package cct_pkg;

   localparam int CHANNELS_DEF  = 6;
   localparam int EVENT_W       = 6;
   localparam int COUNTER_W     = 32;
   localparam int DIV_W         = 9;
   localparam int PRESCALE_W    = 4;
   localparam int PRESCALE_MAX  = 8;
   localparam int PRESCALE_RST  = 4;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 6;
   localparam int WIDTH_MODE_W  = 2;

   typedef enum logic [3:0] {
      KIND_TICK    = 4'd0,
      KIND_START   = 4'd1,
      KIND_STOP    = 4'd2,
      KIND_CLEAR   = 4'd3,
      KIND_COUNT   = 4'd4,
      KIND_CAPTURE = 4'd5,
      KIND_WR_CMP  = 4'd6,
      KIND_RD_CMP  = 4'd7,
      KIND_EV_CLR  = 4'd8
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TIMER_MODE = 3'd0,
      CSR_WIDTH_MODE = 3'd1,
      CSR_PRESCALER  = 3'd2,
      CSR_CLEAR_MASK = 3'd3,
      CSR_IRQ_MASK   = 3'd4
   } csr_addr_type;

   typedef enum logic [WIDTH_MODE_W-1:0] {
      WIDTH_16 = 2'd0,
      WIDTH_8  = 2'd1,
      WIDTH_24 = 2'd2,
      WIDTH_32 = 2'd3
   } width_mode_type;

   localparam logic MODE_TIMER   = 1'b0;
   localparam logic MODE_COUNTER = 1'b1;

   typedef struct packed {
      logic [3:0]           kind;
      logic [2:0]           channel;
      logic [COUNTER_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNTER_W-1:0] read_data;
      logic [EVENT_W-1:0]   compare_events;
      logic                 irq;
   } rsp_type;

   typedef struct packed {
      logic [EVENT_W-1:0] hit;
      logic               clear;
   } match_type;

   function automatic logic [COUNTER_W-1:0] width_mask(input logic [WIDTH_MODE_W-1:0] mode);
      logic [COUNTER_W-1:0] m;
      case (mode)
         WIDTH_8:  m = 32'h0000_00FF;
         WIDTH_24: m = 32'h00FF_FFFF;
         WIDTH_32: m = 32'hFFFF_FFFF;
         default:  m = 32'h0000_FFFF;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/cct_compare.sv
`default_nettype none
module cct_compare #(
   parameter int CHANNELS = cct_pkg::CHANNELS_DEF
) (
   input  logic [cct_pkg::COUNTER_W-1:0] counter_value,
   input  logic [cct_pkg::COUNTER_W-1:0] cmp_values [CHANNELS],
   input  logic [CHANNELS-1:0]           clear_mask,
   output cct_pkg::match_type            match
);
   import cct_pkg::*;

   logic [CHANNELS-1:0] hit;
   logic [EVENT_W-1:0]  hit_wide;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         hit[i] = (cmp_values[i] == counter_value);
      end
      hit_wide                 = '0;
      hit_wide[CHANNELS-1:0]   = hit;
      match.hit                = hit_wide;
      match.clear              = |(hit & clear_mask);
   end

endmodule
`default_nettype wire

>>> rtl/core/compare_capture_timer.sv
`default_nettype none
// Timer/counter with CHANNELS compare/capture channels. Each request beat
// (tick, start, stop, clear, count, capture, compare write/read, event clear)
// is applied in the cycle it is accepted and yields exactly one response beat
// in the next cycle, holding the counter or the selected compare register, the
// pending event flags and the irq level. One beat per cycle sustained unless
// stalled; the single response register is the only buffering, so req_stall
// follows rsp_stall while a response is held. Configuration writes are registered.
module compare_capture_timer #(
   parameter int CHANNELS = cct_pkg::CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cct_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cct_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [cct_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cct_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cct_pkg::*;
   `include "compare_capture_timer_macros.svh"

   localparam int CH_W = $clog2(CHANNELS);

   logic                  timer_mode_ff;
   logic [WIDTH_MODE_W-1:0] width_mode_ff;
   logic [PRESCALE_W-1:0] prescaler_ff;
   logic [EVENT_W-1:0]    clear_mask_ff;
   logic [EVENT_W-1:0]    irq_mask_ff;

   logic [COUNTER_W-1:0]  counter_ff, counter_in;
   logic                  running_ff, running_in;
   logic [DIV_W-1:0]      tick_div_ff, tick_div_in;
   logic [COUNTER_W-1:0]  cmp_ff [CHANNELS];
   logic [COUNTER_W-1:0]  cmp_in [CHANNELS];
   logic [CHANNELS-1:0]   events_ff, events_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_accept;
   logic [CH_W-1:0]       ch_sat;
   logic [COUNTER_W-1:0]  counter_inc;
   logic [DIV_W-1:0]      div_inc;
   logic [DIV_W-1:0]      div_limit;
   logic [PRESCALE_W-1:0] presc_eff;
   logic                  advance;
   logic                  show_cmp;
   logic [EVENT_W-1:0]    events_wide;
   match_type             match;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff <= MODE_TIMER;
         width_mode_ff <= WIDTH_16;
         prescaler_ff  <= PRESCALE_W'(PRESCALE_RST);
         clear_mask_ff <= '0;
         irq_mask_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_TIMER_MODE: timer_mode_ff <= csr_wdata[0];
            CSR_WIDTH_MODE: width_mode_ff <= csr_wdata[WIDTH_MODE_W-1:0];
            CSR_PRESCALER:  prescaler_ff  <= csr_wdata[PRESCALE_W-1:0];
            CSR_CLEAR_MASK: clear_mask_ff <= csr_wdata[EVENT_W-1:0];
            CSR_IRQ_MASK:   irq_mask_ff   <= csr_wdata[EVENT_W-1:0];
            default: ;
         endcase
      end
   end

   assign counter_inc = (counter_ff + 32'd1) & width_mask(width_mode_ff);

   cct_compare #(
      .CHANNELS (CHANNELS)
   ) u_compare (
      .counter_value (counter_inc),
      .cmp_values    (cmp_ff),
      .clear_mask    (clear_mask_ff[CHANNELS-1:0]),
      .match         (match)
   );

   always_comb begin
      counter_in  = counter_ff;
      running_in  = running_ff;
      tick_div_in = tick_div_ff;
      events_in   = events_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         cmp_in[i] = cmp_ff[i];
      end
      advance  = 1'b0;
      show_cmp = 1'b0;

      ch_sat = (req_data.channel > 3'(CHANNELS - 1)) ? CH_W'(CHANNELS - 1)
                                                    : req_data.channel[CH_W-1:0];

      presc_eff = (prescaler_ff > PRESCALE_W'(PRESCALE_MAX)) ? PRESCALE_W'(PRESCALE_MAX)
                                                             : prescaler_ff;
      div_limit = DIV_W'(1) << presc_eff;
      div_inc   = tick_div_ff + DIV_W'(1);

      if (req_accept) begin
         case (req_data.kind)
            KIND_TICK: begin
               if (running_ff && timer_mode_ff == MODE_TIMER) begin
                  if (div_inc >= div_limit) begin
                     tick_div_in = '0;
                     advance     = 1'b1;
                  end else begin
                     tick_div_in = div_inc;
                  end
               end
            end
            KIND_START: running_in = 1'b1;
            KIND_STOP:  running_in = 1'b0;
            KIND_CLEAR: begin
               counter_in  = '0;
               tick_div_in = '0;
            end
            KIND_COUNT: begin
               if (running_ff && timer_mode_ff == MODE_COUNTER) begin
                  advance = 1'b1;
               end
            end
            KIND_CAPTURE: begin
               cmp_in[ch_sat] = counter_ff;
               show_cmp       = 1'b1;
            end
            KIND_WR_CMP: cmp_in[ch_sat] = req_data.value;
            KIND_RD_CMP: show_cmp = 1'b1;
            KIND_EV_CLR: events_in[ch_sat] = 1'b0;
            default: ;
         endcase
      end

      if (advance) begin
         counter_in = match.clear ? '0 : counter_inc;
         events_in  = events_ff | match.hit[CHANNELS-1:0];
      end

      events_wide                 = '0;
      events_wide[CHANNELS-1:0]   = events_in;

      rsp_in.read_data      = show_cmp ? cmp_in[ch_sat] : counter_in;
      rsp_in.compare_events = events_wide;
      rsp_in.irq            = |(events_in & irq_mask_ff[CHANNELS-1:0]);

      rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         running_ff   <= 1'b0;
         tick_div_ff  <= '0;
         events_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cmp_ff[i] <= '0;
         end
      end else begin
         counter_ff   <= counter_in;
         running_ff   <= running_in;
         tick_div_ff  <= tick_div_in;
         events_ff    <= events_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < CHANNELS; i++) begin
            cmp_ff[i] <= cmp_in[i];
         end
      end
   end

   // Response payload loads only on an accepted request beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `CCT_ASSERT_NOW(a_div_bound, clock, reset, 1'b1, tick_div_ff <= DIV_W'(1 << PRESCALE_MAX))
   `CCT_ASSERT_NEXT(a_stop_halts, clock, reset,
      req_accept && req_data.kind == KIND_STOP, !running_ff)
   `CCT_ASSERT_NEXT(a_clear_zero, clock, reset,
      req_accept && req_data.kind == KIND_CLEAR, counter_ff == '0 && tick_div_ff == '0)

endmodule
`default_nettype wire

>>> tb/sv/compare_capture_timer_checker.sv
`default_nettype none
module compare_capture_timer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  cct_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  cct_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [cct_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cct_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import cct_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;

   logic                    mode_r;
   logic [WIDTH_MODE_W-1:0] width_r;
   logic [PRESCALE_W-1:0]   prescale_r;
   logic [EVENT_W-1:0]      clr_mask_r;
   logic [EVENT_W-1:0]      irq_mask_r;

   logic [COUNTER_W-1:0]    count_q;
   logic                    run_q;
   logic [DIV_W-1:0]        div_q;
   logic [COUNTER_W-1:0]    cmp_q [CHANNELS];
   logic [EVENT_W-1:0]      flags_q;

   rsp_type                 beats_due[$];
   int                      fails = 0;

   function automatic logic [COUNTER_W-1:0] wrap_mask(input logic [WIDTH_MODE_W-1:0] w);
      case (w)
         WIDTH_8:  return 32'h0000_00FF;
         WIDTH_24: return 32'h00FF_FFFF;
         WIDTH_32: return 32'hFFFF_FFFF;
         default:  return 32'h0000_FFFF;
      endcase
   endfunction

   function automatic void advance_counter();
      logic hit_clear;
      hit_clear = 1'b0;
      count_q = (count_q + 1) & wrap_mask(width_r);
      for (int i = 0; i < CHANNELS; i++) begin
         if (cmp_q[i] == count_q) begin
            flags_q[i] = 1'b1;
            if (clr_mask_r[i]) hit_clear = 1'b1;
         end
      end
      if (hit_clear) count_q = '0;
   endfunction

   function automatic rsp_type apply_beat(input req_type b);
      int unsigned ch;
      int unsigned shift;
      logic        show_cmp;
      rsp_type     r;
      ch = (b.channel > CHANNELS - 1) ? CHANNELS - 1 : b.channel;
      show_cmp = 1'b0;
      case (b.kind)
         KIND_TICK: begin
            if (run_q && mode_r == MODE_TIMER) begin
               shift = (prescale_r > PRESCALE_MAX) ? PRESCALE_MAX : prescale_r;
               div_q = div_q + 1'b1;
               if (div_q >= (1 << shift)) begin
                  div_q = '0;
                  advance_counter();
               end
            end
         end
         KIND_START: run_q = 1'b1;
         KIND_STOP:  run_q = 1'b0;
         KIND_CLEAR: begin
            count_q = '0;
            div_q   = '0;
         end
         KIND_COUNT: begin
            if (run_q && mode_r == MODE_COUNTER) advance_counter();
         end
         KIND_CAPTURE: begin
            cmp_q[ch] = count_q;
            show_cmp  = 1'b1;
         end
         KIND_WR_CMP: cmp_q[ch] = b.value;
         KIND_RD_CMP: show_cmp = 1'b1;
         KIND_EV_CLR: flags_q[ch] = 1'b0;
         default: ;
      endcase
      r.read_data      = show_cmp ? cmp_q[ch] : count_q;
      r.compare_events = flags_q;
      r.irq            = |(flags_q & irq_mask_r);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode_r     = MODE_TIMER;
         width_r    = WIDTH_16;
         prescale_r = PRESCALE_W'(PRESCALE_RST);
         clr_mask_r = '0;
         irq_mask_r = '0;
         count_q    = '0;
         run_q      = 1'b0;
         div_q      = '0;
         flags_q    = '0;
         for (int i = 0; i < CHANNELS; i++) cmp_q[i] = '0;
         beats_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               fails++;
               if (fails <= 10) $display("unexpected response beat %h", rsp_data);
            end else begin
               want = beats_due.pop_front();
               if (rsp_data.read_data !== want.read_data ||
                   rsp_data.compare_events !== want.compare_events ||
                   rsp_data.irq !== want.irq) begin
                  fails++;
                  if (fails <= 10)
                     $display({"mismatch: read_data exp %h got %h, ",
                               "events exp %h got %h, irq exp %b got %b"},
                              want.read_data, rsp_data.read_data, want.compare_events,
                              rsp_data.compare_events, want.irq, rsp_data.irq);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_TIMER_MODE: mode_r     = csr_wdata[0];
               CSR_WIDTH_MODE: width_r    = csr_wdata[WIDTH_MODE_W-1:0];
               CSR_PRESCALER:  prescale_r = csr_wdata[PRESCALE_W-1:0];
               CSR_CLEAR_MASK: clr_mask_r = csr_wdata[EVENT_W-1:0];
               CSR_IRQ_MASK:   irq_mask_r = csr_wdata[EVENT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) beats_due.push_back(apply_beat(req_data));
      end
      pending    = beats_due.size();
      fail_count = fails;
   end

endmodule
`default_nettype wire

>>> tb/sv/tb_compare_capture_timer.sv
`default_nettype none
module tb_compare_capture_timer;
   import cct_pkg::*;

   localparam int LIMIT       = 200000;
   localparam int BLOCKS      = 12;
   localparam int BLOCK_BEATS = 120;
   localparam int RUN_BEATS   = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   cycles       = 0;
   int   tx_idle_pct  = 17;
   int   rx_idle_pct  = 71;
   logic cur_mode     = MODE_TIMER;

   compare_capture_timer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   compare_capture_timer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_timer(input logic [CSR_DATA_W-1:0] mode_v,
                                input logic [CSR_DATA_W-1:0] width_v,
                                input logic [CSR_DATA_W-1:0] pre_v,
                                input logic [CSR_DATA_W-1:0] clr_v,
                                input logic [CSR_DATA_W-1:0] irq_v);
      write_reg(CSR_TIMER_MODE, mode_v);
      write_reg(CSR_WIDTH_MODE, width_v);
      write_reg(CSR_PRESCALER, pre_v);
      write_reg(CSR_CLEAR_MASK, clr_v);
      write_reg(CSR_IRQ_MASK, irq_v);
      // unmapped index, must be ignored
      write_reg(CSR_ADDR_W'($urandom_range(int'(CSR_IRQ_MASK) + 1, (1 << CSR_ADDR_W) - 1)),
                CSR_DATA_W'($urandom()));
      cur_mode = mode_v[0];
   endtask

   function automatic req_type make_beat(input logic [3:0] kind, input int unsigned ch,
                                         input logic [COUNTER_W-1:0] val);
      req_type b;
      b.kind    = kind;
      b.channel = 3'(ch);
      b.value   = val;
      return b;
   endfunction

   function automatic logic [COUNTER_W-1:0] pick_value();
      case ($urandom_range(9))
         6:       return $urandom();
         7:       return {24'($urandom_range(1, 16777215)), 8'($urandom_range(24))};
         8:       return {8'($urandom_range(1, 255)), 24'($urandom_range(24))};
         9:       return 32'hFFFF_FFFF;
         default: return COUNTER_W'($urandom_range(24));
      endcase
   endfunction

   function automatic req_type pick_beat(input int advance_pct);
      req_type b;
      b.channel = 3'($urandom_range(7));
      b.value   = pick_value();
      if ($urandom_range(99) < advance_pct) begin
         b.kind = (cur_mode == MODE_COUNTER) ? KIND_COUNT : KIND_TICK;
      end else begin
         case ($urandom_range(11))
            0:       b.kind = KIND_TICK;
            1, 2:    b.kind = KIND_START;
            3:       b.kind = KIND_STOP;
            4:       b.kind = KIND_CLEAR;
            5:       b.kind = KIND_COUNT;
            6:       b.kind = KIND_CAPTURE;
            7, 8:    b.kind = KIND_WR_CMP;
            9:       b.kind = KIND_RD_CMP;
            10:      b.kind = KIND_EV_CLR;
            default: b.kind = 4'($urandom_range(int'(KIND_EV_CLR) + 1, 15));
         endcase
      end
      return b;
   endfunction

   initial begin
      int blk;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      program_timer(CSR_DATA_W'(MODE_TIMER), CSR_DATA_W'(WIDTH_16), CSR_DATA_W'(0),
                    6'b100000, 6'b000010);
      send_beat(make_beat(KIND_RD_CMP, 7, '0));
      send_beat(make_beat(KIND_WR_CMP, 0, 32'hFFFF_FFFF));
      send_beat(make_beat(KIND_WR_CMP, 7, 32'd2));
      send_beat(make_beat(KIND_WR_CMP, 1, 32'd1));
      send_beat(make_beat(KIND_TICK, 0, '0));
      send_beat(make_beat(KIND_START, 0, '0));
      send_beat(make_beat(KIND_START, 0, '0));
      send_beat(make_beat(KIND_COUNT, 0, '0));
      send_beat(make_beat(KIND_TICK, 0, '0));
      send_beat(make_beat(KIND_TICK, 0, '0));
      send_beat(make_beat(KIND_CAPTURE, 2, '0));
      send_beat(make_beat(KIND_EV_CLR, 1, '0));
      send_beat(make_beat(KIND_EV_CLR, 6, '0));
      send_beat(make_beat(KIND_STOP, 0, '0));
      send_beat(make_beat(KIND_TICK, 0, '0));
      send_beat(make_beat(KIND_CLEAR, 0, '0));
      send_beat(make_beat(4'($urandom_range(int'(KIND_EV_CLR) + 1, 15)), 3, $urandom()));
      send_beat(make_beat(KIND_RD_CMP, 0, '0));
      send_beat(make_beat(KIND_WR_CMP, 0, '0));

      for (blk = 0; blk < BLOCKS; blk++) begin
         drain_results();
         if (blk == BLOCKS / 3) begin
            tx_idle_pct = 71;
            rx_idle_pct = 17;
         end else if (blk == 2 * BLOCKS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (blk)
            0:       program_timer(CSR_DATA_W'(MODE_TIMER), CSR_DATA_W'(WIDTH_8),
                                   CSR_DATA_W'(0), CSR_DATA_W'(0), 6'h3F);
            1:       program_timer(6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F);
            2:       program_timer(6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
            3:       program_timer(CSR_DATA_W'(MODE_COUNTER), CSR_DATA_W'(WIDTH_8),
                                   CSR_DATA_W'(8), CSR_DATA_W'(0), 6'h3F);
            default: program_timer(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                                   CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                                   CSR_DATA_W'($urandom()));
         endcase
         send_beat(make_beat(KIND_START, $urandom_range(7), $urandom()));
         // long uninterrupted run so the 8-bit counter wraps
         if (blk == 0 || blk == 3) begin
            repeat (RUN_BEATS)
               send_beat(make_beat(cur_mode == MODE_COUNTER ? KIND_COUNT : KIND_TICK,
                                   $urandom_range(7), $urandom()));
         end
         repeat (BLOCK_BEATS) send_beat(pick_beat(50));
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
